// ===== src/fbbf_pkg.sv =====
`default_nettype none

package fbbf_pkg;

    // Fixed point format of positions, forces, torques, energy and coefficients.
    localparam int FRAC_BITS = 16;
    localparam logic [19:0] ONE_Q = 20'(1 << FRAC_BITS);
    localparam logic [19:0] TENTH_Q = 20'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic [45:0] FORCE_CAP = {46{1'b1}};
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MIN = 32'h8000_0000;

    // Reciprocal of five for the site offset, eighteen fraction bits.
    localparam logic [15:0] RECIP5_Q18 = 16'd52429;

    // Register map: three coefficients for each bond type.
    localparam int REGS_PER_TYPE = 3;
    localparam int REG_K = 0;
    localparam int REG_DELTA = 1;
    localparam int REG_R0 = 2;
    localparam logic [23:0] K_RESET = 24'd131072;
    localparam logic [23:0] DELTA_RESET = 24'd16384;
    localparam logic [23:0] R0_RESET = 24'd49316;

    // Status codes.
    localparam logic [1:0] STAT_OK = 2'd0;
    localparam logic [1:0] STAT_NEAR = 2'd1;
    localparam logic [1:0] STAT_PAST = 2'd2;
    localparam logic [1:0] STAT_BAD = 2'd3;

    // Step counts of the iterative units.
    localparam int SQRT_STEPS = 28;
    localparam int TDIV_STEPS = 17;
    localparam int PDIV_STEPS = 41;
    localparam int LOG_STEPS = 16;
    localparam int FDIV_STEPS = 46;

    // Pipeline stage map.
    localparam int ST_OFS = 1;
    localparam int ST_DR = 2;
    localparam int ST_SQ = 3;
    localparam int ST_SUM = 4;
    localparam int ST_SQRT0 = 5;
    localparam int ST_RCHK = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_TDIV0 = ST_RCHK + 1;
    localparam int ST_RL = ST_TDIV0 + TDIV_STEPS;
    localparam int ST_PDIV0 = ST_RL + 1;
    localparam int ST_LNORM = ST_PDIV0;
    localparam int ST_LSQ0 = ST_LNORM + 1;
    localparam int ST_LMUL = ST_LSQ0 + LOG_STEPS;
    localparam int ST_EMUL = ST_LMUL + 1;
    localparam int ST_FINIT = ST_PDIV0 + PDIV_STEPS;
    localparam int ST_FDIV0 = ST_FINIT + 1;
    localparam int ST_FPP = ST_FDIV0 + FDIV_STEPS;
    localparam int ST_FSUM = ST_FPP + 1;
    localparam int ST_TPROD = ST_FSUM + 1;
    localparam int ST_OUT = ST_TPROD + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    typedef struct packed {
        logic [2:0][31:0] force_v;
        logic [2:0][31:0] torque_a;
        logic [2:0][31:0] torque_b;
        logic [31:0]      energy;
        logic [1:0]       status;
    } res_t;

    typedef struct packed {
        logic [23:0]      k;
        logic [23:0]      dl;
        logic [23:0]      r0;
        logic [2:0][31:0] cen;
        logic [2:0][15:0] axa;
        logic [2:0][15:0] axb;
        logic [2:0][16:0] ra;
        logic [2:0][16:0] rb;
        logic [2:0][26:0] drmag;
        logic [2:0]       drneg;
        logic [2:0][53:0] sq;
        logic [55:0]      sx;
        logic [28:0]      srem;
        logic [27:0]      root;
        logic             bad;
        logic             rpos;
        logic [23:0]      trem;
        logic [16:0]      tq;
        logic [2:0][27:0] nrem;
        logic [2:0][16:0] nq;
        logic [19:0]      rl;
        logic [1:0]       status;
        logic             neg;
        logic [23:0]      prem;
        logic [40:0]      pq;
        logic [30:0]      ly;
        logic [4:0]       lp;
        logic [15:0]      lfrac;
        logic [19:0]      lnmag;
        logic [31:0]      energy;
        logic             pzero;
        logic             ovf;
        logic [18:0]      dd;
        logic [18:0]      frem;
        logic [45:0]      fq;
        logic [2:0][39:0] pph;
        logic [2:0][39:0] ppl;
        logic [2:0][31:0] f;
        logic [2:0][48:0] ap1;
        logic [2:0][48:0] ap2;
        logic [2:0][48:0] bp1;
        logic [2:0][48:0] bp2;
        res_t             res;
    } item_t;

endpackage

`default_nettype wire

// ===== src/fene_backbone_bond_force.sv =====
// Throughput: one bond per cycle while the skid register is empty; the
// stages of the square root and of the three dividers each resolve one
// quotient or root bit, and every stage takes a new word.
// Reset (aresetn low, synchronous): valid bits cleared, coefficients take their reset
// values. There is no clearing pass; the block takes words in the first cycle after reset.
`default_nettype none

module fene_backbone_bond_force
    import fbbf_pkg::*;
#(
    parameter int NUM_TYPES = 2,
    localparam int ADDR_W = $clog2(REGS_PER_TYPE * NUM_TYPES) + 2
) (
    input  wire                aclk,
    input  wire                aresetn,
    // Configuration port
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [ADDR_W-1:0]  paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Input channel
    input  wire                s_valid,
    output logic               s_ready,
    input  wire                s_bond_type,
    input  wire  signed [31:0] s_center_dx,
    input  wire  signed [31:0] s_center_dy,
    input  wire  signed [31:0] s_center_dz,
    input  wire  signed [15:0] s_axis_a_x,
    input  wire  signed [15:0] s_axis_a_y,
    input  wire  signed [15:0] s_axis_a_z,
    input  wire  signed [15:0] s_axis_b_x,
    input  wire  signed [15:0] s_axis_b_y,
    input  wire  signed [15:0] s_axis_b_z,
    // Result channel
    output logic               m_valid,
    input  wire                m_ready,
    output logic signed [31:0] m_force_x,
    output logic signed [31:0] m_force_y,
    output logic signed [31:0] m_force_z,
    output logic signed [31:0] m_torque_a_x,
    output logic signed [31:0] m_torque_a_y,
    output logic signed [31:0] m_torque_a_z,
    output logic signed [31:0] m_torque_b_x,
    output logic signed [31:0] m_torque_b_y,
    output logic signed [31:0] m_torque_b_z,
    output logic signed [31:0] m_bond_energy,
    output logic [1:0]         m_bond_status
);

    localparam int IDX_W = ADDR_W - 2;

    logic [23:0] k_reg [NUM_TYPES];
    logic [23:0] dl_reg [NUM_TYPES];
    logic [23:0] r0_reg [NUM_TYPES];

    item_t pipe_reg [NUM_STAGES];
    logic  vld_reg [NUM_STAGES];
    item_t stage_next [NUM_STAGES];
    item_t in_item;

    res_t  out_reg;
    res_t  skid_reg;
    logic  out_vld_reg;
    logic  skid_vld_reg;

    logic  pipe_en;
    logic  push;
    logic  take;
    logic  cfg_wr;
    logic [IDX_W-1:0] cfg_idx;

    // Site offset: -0.4 times a Q1.14 axis component, as floor(|ax|*8/5) with the sign flipped.
    function automatic logic [16:0] site_ofs(input logic [15:0] ax);
        logic [16:0] mag;
        logic [18:0] x;
        logic [34:0] prod;
        logic [16:0] q;
        logic [19:0] q5;
        mag = ax[15] ? (17'd0 - {1'b1, ax}) : {1'b0, ax};
        x = 19'({mag, 3'b000});
        prod = {16'd0, x} * {19'd0, RECIP5_Q18};
        q = prod[34:18];
        q5 = {1'b0, q, 2'b00} + {3'b000, q};
        if (q5 > {1'b0, x}) begin
            q = q - 17'd1;
        end
        return (!ax[15] && (ax != 16'd0)) ? (17'd0 - q) : q;
    endfunction

    // Force component: sign applied to a magnitude, then saturated to 32 bits.
    function automatic logic [31:0] sat_signed(input logic [47:0] m, input logic sneg);
        logic [31:0] v;
        if (!sneg) begin
            v = (m > {16'd0, POS_MAX}) ? POS_MAX : m[31:0];
        end else begin
            v = (m > {16'd0, NEG_MIN}) ? NEG_MIN : (32'd0 - m[31:0]);
        end
        return v;
    endfunction

    // Torque component: difference of two products, truncated toward zero, saturated.
    function automatic logic [31:0] torque_sat(input logic [48:0] p1, input logic [48:0] p2);
        logic signed [49:0] d;
        logic [49:0] mag;
        logic [33:0] s;
        logic [31:0] v;
        d = $signed({p1[48], p1}) - $signed({p2[48], p2});
        mag = d[49] ? (50'd0 - d) : d;
        s = mag[49:16];
        if (!d[49]) begin
            v = (s > {2'd0, POS_MAX}) ? POS_MAX : s[31:0];
        end else begin
            v = (s > {2'd0, NEG_MIN}) ? NEG_MIN : (32'd0 - s[31:0]);
        end
        return v;
    endfunction

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < NUM_TYPES; t++) begin
                k_reg[t] <= K_RESET;
                dl_reg[t] <= DELTA_RESET;
                r0_reg[t] <= R0_RESET;
            end
        end else if (cfg_wr) begin
            for (int t = 0; t < NUM_TYPES; t++) begin
                if (cfg_idx == IDX_W'(REGS_PER_TYPE * t + REG_K)) begin
                    k_reg[t] <= pwdata[23:0];
                end
                if (cfg_idx == IDX_W'(REGS_PER_TYPE * t + REG_DELTA)) begin
                    dl_reg[t] <= pwdata[23:0];
                end
                if (cfg_idx == IDX_W'(REGS_PER_TYPE * t + REG_R0)) begin
                    r0_reg[t] <= pwdata[23:0];
                end
            end
        end
    end

    // Register read-back; unused addresses read as zero.
    always_comb begin
        prdata = '0;
        for (int t = 0; t < NUM_TYPES; t++) begin
            if (cfg_idx == IDX_W'(REGS_PER_TYPE * t + REG_K)) begin
                prdata = {8'd0, k_reg[t]};
            end
            if (cfg_idx == IDX_W'(REGS_PER_TYPE * t + REG_DELTA)) begin
                prdata = {8'd0, dl_reg[t]};
            end
            if (cfg_idx == IDX_W'(REGS_PER_TYPE * t + REG_R0)) begin
                prdata = {8'd0, r0_reg[t]};
            end
        end
    end

    // Input word with its coefficient set; a type beyond the last set uses the last set.
    always_comb begin
        in_item = '0;
        in_item.k = k_reg[NUM_TYPES-1];
        in_item.dl = dl_reg[NUM_TYPES-1];
        in_item.r0 = r0_reg[NUM_TYPES-1];
        for (int t = 0; t < NUM_TYPES - 1; t++) begin
            if (int'(s_bond_type) == t) begin
                in_item.k = k_reg[t];
                in_item.dl = dl_reg[t];
                in_item.r0 = r0_reg[t];
            end
        end
        in_item.cen = {s_center_dz, s_center_dy, s_center_dx};
        in_item.axa = {s_axis_a_z, s_axis_a_y, s_axis_a_x};
        in_item.axb = {s_axis_b_z, s_axis_b_y, s_axis_b_x};
    end

    // The whole pipeline moves while the skid register is empty.
    assign pipe_en = !skid_vld_reg;
    assign s_ready = pipe_en;
    assign stage_next[0] = in_item;

    // Stage logic: each stage applies its own step to the word from the stage before.
    for (genvar g = 1; g < NUM_STAGES; g++) begin : g_stage
        always_comb begin
            item_t it;
            logic signed [33:0] d;
            logic [33:0] dmag;
            logic signed [28:0] rr;
            logic [28:0] rm;
            logic [30:0] scur;
            logic [30:0] strial;
            logic [24:0] cur25;
            logic [28:0] cur29;
            logic [19:0] cur20;
            logic ge;
            logic [33:0] tt;
            logic signed [19:0] rls;
            logic [16:0] lx;
            logic [46:0] lsh;
            logic [61:0] lsq;
            logic [31:0] y2;
            logic [20:0] lmag;
            logic [50:0] lprod;
            logic [43:0] eprod;
            logic [45:0] fb;
            logic [63:0] msum;
            int j;
            int h;

            it = pipe_reg[g-1];
            rls = $signed(it.rl);

            // Backbone site offsets of both particles.
            if (g == ST_OFS) begin
                for (int i = 0; i < 3; i++) begin
                    it.ra[i] = site_ofs(it.axa[i]);
                    it.rb[i] = site_ofs(it.axb[i]);
                end
            end

            // Site separation and the far-bond test.
            if (g == ST_DR) begin
                it.bad = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    d = $signed({{2{it.cen[i][31]}}, it.cen[i]})
                        + $signed({{17{it.ra[i][16]}}, it.ra[i]})
                        - $signed({{17{it.rb[i][16]}}, it.rb[i]});
                    dmag = d[33] ? (34'd0 - d) : d;
                    if (dmag[33:27] != 7'd0) begin
                        it.bad = 1'b1;
                    end
                    it.drmag[i] = dmag[26:0];
                    it.drneg[i] = d[33];
                end
            end

            // Squares of the separation components.
            if (g == ST_SQ) begin
                for (int i = 0; i < 3; i++) begin
                    it.sq[i] = {27'd0, it.drmag[i]} * {27'd0, it.drmag[i]};
                end
            end

            // Sum of squares; the square root starts from zero.
            if (g == ST_SUM) begin
                it.sx = {2'd0, it.sq[0]} + {2'd0, it.sq[1]} + {2'd0, it.sq[2]};
                it.srem = '0;
                it.root = '0;
            end

            // One root bit per stage.
            if (g >= ST_SQRT0 && g < ST_SQRT0 + SQRT_STEPS) begin
                scur = {it.srem, it.sx[55:54]};
                strial = {1'b0, it.root, 2'b01};
                if (scur >= strial) begin
                    it.srem = 29'(scur - strial);
                    it.root = {it.root[26:0], 1'b1};
                end else begin
                    it.srem = scur[28:0];
                    it.root = {it.root[26:0], 1'b0};
                end
                it.sx = {it.sx[53:0], 2'b00};
            end

            // Extension from rest length, range checks, divider set-up.
            if (g == ST_RCHK) begin
                rr = $signed({1'b0, it.root}) - $signed({5'd0, it.r0});
                rm = rr[28] ? (29'd0 - rr) : rr;
                it.rpos = !rr[28] && (rr != 29'sd0);
                if ((it.root == 28'd0) || (it.dl == 24'd0) || (rm >= {4'd0, it.dl, 1'b0})) begin
                    it.bad = 1'b1;
                end
                it.trem = rm[24:1];
                it.tq = {rm[0], 16'd0};
                for (int i = 0; i < 3; i++) begin
                    it.nrem[i] = {2'd0, it.drmag[i][26:1]};
                    it.nq[i] = {it.drmag[i][0], 16'd0};
                end
            end

            // Relative extension t and the unit direction, one quotient bit per stage.
            if (g >= ST_TDIV0 && g < ST_TDIV0 + TDIV_STEPS) begin
                cur25 = {it.trem, it.tq[16]};
                ge = (cur25 >= {1'b0, it.dl});
                it.trem = ge ? 24'(cur25 - {1'b0, it.dl}) : cur25[23:0];
                it.tq = {it.tq[15:0], ge};
                for (int i = 0; i < 3; i++) begin
                    cur29 = {it.nrem[i], it.nq[i][16]};
                    ge = (cur29 >= {1'b0, it.root});
                    it.nrem[i] = ge ? 28'(cur29 - {1'b0, it.root}) : cur29[27:0];
                    it.nq[i] = {it.nq[i][15:0], ge};
                end
            end

            // Log argument, status, force sign and the numerator k*t.
            if (g == ST_RL) begin
                tt = {17'd0, it.tq} * {17'd0, it.tq};
                it.rl = ONE_Q - {2'd0, tt[33:16]};
                rls = $signed(it.rl);
                if (rls <= 20'sd0) begin
                    it.status = STAT_PAST;
                end else if (rls < $signed(TENTH_Q)) begin
                    it.status = STAT_NEAR;
                end else begin
                    it.status = STAT_OK;
                end
                it.neg = it.rpos ? !it.rl[19] : it.rl[19];
                it.pq = {17'd0, it.k} * {24'd0, it.tq};
                it.prem = '0;
            end

            // Quotient p = k*t / Delta, one bit per stage.
            if (g >= ST_PDIV0 && g < ST_PDIV0 + PDIV_STEPS) begin
                cur25 = {it.prem, it.pq[40]};
                ge = (cur25 >= {1'b0, it.dl});
                it.prem = ge ? 24'(cur25 - {1'b0, it.dl}) : cur25[23:0];
                it.pq = {it.pq[39:0], ge};
            end

            // Log: normalise the argument into [1, 2) with thirty fraction bits.
            if (g == ST_LNORM) begin
                lx = (rls > 20'sd0) ? it.rl[16:0] : 17'd1;
                it.lp = '0;
                for (int b = 0; b < 17; b++) begin
                    if (lx[b]) begin
                        it.lp = 5'(b);
                    end
                end
                lsh = {lx, 30'd0} >> it.lp;
                it.ly = lsh[30:0];
                it.lfrac = '0;
            end

            // Log: one fraction bit of log2 per squaring.
            if (g >= ST_LSQ0 && g < ST_LSQ0 + LOG_STEPS) begin
                lsq = {31'd0, it.ly} * {31'd0, it.ly};
                y2 = lsq[61:30];
                it.ly = y2[31] ? y2[31:1] : y2[30:0];
                it.lfrac = {it.lfrac[14:0], y2[31]};
            end

            // Log: magnitude of log2, scaled to a natural log.
            if (g == ST_LMUL) begin
                lmag = {5'(5'd16 - it.lp), 16'd0} - {5'd0, it.lfrac};
                lprod = {30'd0, lmag} * {21'd0, LN2_Q30};
                it.lnmag = lprod[49:30];
            end

            // Energy: half k times the log magnitude; saturates past the limit.
            if (g == ST_EMUL) begin
                eprod = {20'd0, it.k} * {24'd0, it.lnmag};
                it.energy = (rls <= 20'sd0) ? POS_MAX : {5'd0, eprod[43:17]};
            end

            // Force magnitude divider set-up with the overflow test against the cap.
            if (g == ST_FINIT) begin
                it.dd = it.rl[19] ? 19'(20'd0 - it.rl) : it.rl[18:0];
                it.pzero = (it.pq == 41'd0);
                it.ovf = ({8'd0, it.pq[40:30]} >= it.dd);
                it.frem = {8'd0, it.pq[40:30]};
                it.fq = {it.pq[29:0], 16'd0};
            end

            // Force magnitude p / |rlogarg|, one bit per stage.
            if (g >= ST_FDIV0 && g < ST_FDIV0 + FDIV_STEPS) begin
                cur20 = {it.frem, it.fq[45]};
                ge = (cur20 >= {1'b0, it.dd});
                it.frem = ge ? 19'(cur20 - {1'b0, it.dd}) : cur20[18:0];
                it.fq = {it.fq[44:0], ge};
            end

            // Force magnitude times the unit direction, in two partial products.
            if (g == ST_FPP) begin
                if (it.pzero) begin
                    fb = '0;
                end else if (it.ovf) begin
                    fb = FORCE_CAP;
                end else begin
                    fb = it.fq;
                end
                for (int i = 0; i < 3; i++) begin
                    it.pph[i] = {17'd0, fb[45:23]} * {23'd0, it.nq[i]};
                    it.ppl[i] = {17'd0, fb[22:0]} * {23'd0, it.nq[i]};
                end
            end

            // Force components with sign and saturation.
            if (g == ST_FSUM) begin
                for (int i = 0; i < 3; i++) begin
                    msum = {1'b0, it.pph[i], 23'd0} + {24'd0, it.ppl[i]};
                    it.f[i] = sat_signed(msum[63:16], it.neg ^ it.drneg[i]);
                end
            end

            // Cross products of the site offsets with the force.
            if (g == ST_TPROD) begin
                for (int i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    h = (i + 2) % 3;
                    it.ap1[i] = 49'($signed(it.ra[j]) * $signed(it.f[h]));
                    it.ap2[i] = 49'($signed(it.ra[h]) * $signed(it.f[j]));
                    it.bp1[i] = 49'($signed(it.rb[h]) * $signed(it.f[j]));
                    it.bp2[i] = 49'($signed(it.rb[j]) * $signed(it.f[h]));
                end
            end

            // Torques and the final result; a bad bond gives zeros.
            if (g == ST_OUT) begin
                it.res = '0;
                it.res.status = STAT_BAD;
                if (!it.bad) begin
                    for (int i = 0; i < 3; i++) begin
                        it.res.force_v[i] = it.f[i];
                        it.res.torque_a[i] = torque_sat(it.ap1[i], it.ap2[i]);
                        it.res.torque_b[i] = torque_sat(it.bp1[i], it.bp2[i]);
                    end
                    it.res.energy = it.energy;
                    it.res.status = it.status;
                end
            end

            stage_next[g] = it;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NUM_STAGES; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (pipe_en) begin
            vld_reg[0] <= s_valid;
            for (int s = 1; s < NUM_STAGES; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // Pipeline data.
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int s = 0; s < NUM_STAGES; s++) begin
                pipe_reg[s] <= stage_next[s];
            end
        end
    end

    // Output register with a skid register behind it.
    assign push = pipe_en && vld_reg[NUM_STAGES-1];
    assign take = out_vld_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_ready) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_vld_reg && !m_ready) begin
                skid_vld_reg <= 1'b1;
            end
            out_vld_reg <= 1'b1;
        end else if (take) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (out_vld_reg && !m_ready) begin
                skid_reg <= pipe_reg[NUM_STAGES-1].res;
            end else begin
                out_reg <= pipe_reg[NUM_STAGES-1].res;
            end
        end
    end

    assign m_valid = out_vld_reg;
    assign m_force_x = out_reg.force_v[0];
    assign m_force_y = out_reg.force_v[1];
    assign m_force_z = out_reg.force_v[2];
    assign m_torque_a_x = out_reg.torque_a[0];
    assign m_torque_a_y = out_reg.torque_a[1];
    assign m_torque_a_z = out_reg.torque_a[2];
    assign m_torque_b_x = out_reg.torque_b[0];
    assign m_torque_b_y = out_reg.torque_b[1];
    assign m_torque_b_z = out_reg.torque_b[2];
    assign m_bond_energy = out_reg.energy;
    assign m_bond_status = out_reg.status;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none

module testbench;
    import fbbf_pkg::*;

    localparam int LATENCY = 145;
    localparam int STALL_LIMIT = 4000;
    localparam longint FAR_EDGE = 64'sd1 << 27;

    // One bond as it is driven on the s_ side.
    typedef struct packed {
        logic             typ;
        logic [2:0][31:0] cen;
        logic [2:0][15:0] axa;
        logic [2:0][15:0] axb;
    } bond_t;

    typedef struct packed {
        bond_t bond;
        logic  typed;
        res_t  res;
    } bond_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_bond_type = 1'b0;
    logic signed [31:0] s_center_dx = '0, s_center_dy = '0, s_center_dz = '0;
    logic signed [15:0] s_axis_a_x = '0, s_axis_a_y = '0, s_axis_a_z = '0;
    logic signed [15:0] s_axis_b_x = '0, s_axis_b_y = '0, s_axis_b_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_force_x, m_force_y, m_force_z;
    logic signed [31:0] m_torque_a_x, m_torque_a_y, m_torque_a_z;
    logic signed [31:0] m_torque_b_x, m_torque_b_y, m_torque_b_z;
    logic signed [31:0] m_bond_energy;
    logic [1:0] m_bond_status;

    fene_backbone_bond_force u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_bond_type(s_bond_type),
        .s_center_dx(s_center_dx), .s_center_dy(s_center_dy), .s_center_dz(s_center_dz),
        .s_axis_a_x(s_axis_a_x), .s_axis_a_y(s_axis_a_y), .s_axis_a_z(s_axis_a_z),
        .s_axis_b_x(s_axis_b_x), .s_axis_b_y(s_axis_b_y), .s_axis_b_z(s_axis_b_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_force_x(m_force_x), .m_force_y(m_force_y), .m_force_z(m_force_z),
        .m_torque_a_x(m_torque_a_x), .m_torque_a_y(m_torque_a_y),
        .m_torque_a_z(m_torque_a_z), .m_torque_b_x(m_torque_b_x),
        .m_torque_b_y(m_torque_b_y), .m_torque_b_z(m_torque_b_z),
        .m_bond_energy(m_bond_energy), .m_bond_status(m_bond_status)
    );

    always #6 aclk = ~aclk;

    // Coefficients as the block should hold them.
    longint coef_k[2], coef_delta[2], coef_r0[2];
    res_t expected_results[$];
    int mismatches = 0;
    int bonds_sent = 0;
    int results_seen = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int stall_cycles = 0;
    bit no_gaps = 1'b0;

    // Fixed point helpers.
    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint with_sign(longint unsigned m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint shr_tz(longint v, int s);
        return with_sign(mag(v) >> s, v < 0);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Backbone site sits at -0.4 times the axis.
    function automatic longint site_ofs(logic [15:0] a);
        longint ax;
        longint unsigned m;
        ax = longint'($signed(a));
        m = ((mag(ax) * 2) << FRAC_BITS) / (5 << 14);
        return with_sign(m, ax > 0);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Natural log of x in (0, 1], bit by bit through log2.
    function automatic longint ln_q(longint x);
        int p;
        longint unsigned y, frac;
        longint l;
        p = 0;
        frac = 0;
        while (p < 62 && (x >> (p + 1)) != 0) p++;
        y = longint'(x) << (30 - p);
        for (int i = 0; i < FRAC_BITS; i++) begin
            y = (y * y) >> 30;
            frac <<= 1;
            if (y >= (64'd1 << 31)) begin
                y >>= 1;
                frac |= 1;
            end
        end
        l = longint'(p - FRAC_BITS) * (64'sd1 << FRAC_BITS) + longint'(frac);
        return shr_tz(l * longint'(LN2_Q30), 30);
    endfunction

    // Expected force, torques, energy and status of one bond.
    function automatic res_t bond_force(bond_t b);
        res_t res;
        longint k, dl, r0, rr0, rl, fb;
        longint dr[3], ra[3], rb[3], f[3];
        longint unsigned rsq, r, t, p, d, q1, rmag, n, m;
        bit neg;
        int j, h;
        res = '0;
        res.status = STAT_BAD;
        k = coef_k[b.typ];
        dl = coef_delta[b.typ];
        r0 = coef_r0[b.typ];
        rsq = 0;
        for (int i = 0; i < 3; i++) begin
            ra[i] = site_ofs(b.axa[i]);
            rb[i] = site_ofs(b.axb[i]);
            dr[i] = longint'($signed(b.cen[i])) + ra[i] - rb[i];
            if (mag(dr[i]) >= FAR_EDGE) return res;
        end
        for (int i = 0; i < 3; i++) rsq += mag(dr[i]) * mag(dr[i]);
        r = int_sqrt(rsq);
        if (r == 0 || dl == 0) return res;
        rr0 = longint'(r) - r0;
        rmag = mag(rr0);
        if (rmag >= 2 * dl) return res;

        t = (rmag << FRAC_BITS) / dl;
        rl = (64'sd1 << FRAC_BITS) - longint'((t * t) >> FRAC_BITS);
        res.status = rl <= 0 ? STAT_PAST : (rl < longint'(TENTH_Q) ? STAT_NEAR : STAT_OK);

        // Force magnitude, capped.
        p = (k * t) / dl;
        if (p == 0) begin
            fb = 0;
        end else if (rl == 0) begin
            fb = longint'(FORCE_CAP);
        end else begin
            d = mag(rl);
            q1 = p / d;
            if (q1 > (longint'(FORCE_CAP) >> FRAC_BITS)) begin
                fb = longint'(FORCE_CAP);
            end else begin
                fb = longint'((q1 << FRAC_BITS) + (((p % d) << FRAC_BITS) / d));
                if (fb > longint'(FORCE_CAP)) fb = longint'(FORCE_CAP);
            end
        end
        neg = (rr0 > 0) ? (rl >= 0) : (rl < 0);

        for (int i = 0; i < 3; i++) begin
            n = (mag(dr[i]) << FRAC_BITS) / r;
            m = (longint'(fb) * n) >> FRAC_BITS;
            f[i] = sat32(with_sign(m, neg != (dr[i] < 0)));
            res.force_v[i] = 32'(f[i]);
        end
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            h = (i + 2) % 3;
            res.torque_a[i] = 32'(sat32(shr_tz(ra[j] * f[h] - ra[h] * f[j], FRAC_BITS)));
            res.torque_b[i] = 32'(sat32(shr_tz(rb[h] * f[j] - rb[j] * f[h], FRAC_BITS)));
        end
        if (rl <= 0) res.energy = POS_MAX;
        else res.energy = 32'(sat32(shr_tz(-(k * ln_q(rl)), FRAC_BITS + 1)));
        return res;
    endfunction

    function automatic bond_t mk_bond(bit typ, longint dx, longint dy, longint dz,
                                      longint ax, longint ay, longint az,
                                      longint bx, longint by, longint bz);
        bond_t b;
        b.typ = typ;
        b.cen[0] = 32'(dx);
        b.cen[1] = 32'(dy);
        b.cen[2] = 32'(dz);
        b.axa[0] = 16'(ax);
        b.axa[1] = 16'(ay);
        b.axa[2] = 16'(az);
        b.axb[0] = 16'(bx);
        b.axb[1] = 16'(by);
        b.axb[2] = 16'(bz);
        return b;
    endfunction

    function automatic res_t flat_result(logic [1:0] st);
        res_t res;
        res = '0;
        res.status = st;
        return res;
    endfunction

    function automatic logic [15:0] any_axis();
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    // Random bond: mostly near the rest length so that every regime is visited.
    function automatic bond_t random_bond();
        bond_t b;
        int mode, pi;
        longint span, target, delr[3];
        mode = $urandom_range(0, 99);
        b.typ = 1'($urandom_range(0, 1));
        for (int i = 0; i < 3; i++) begin
            b.axa[i] = any_axis();
            b.axb[i] = any_axis();
            b.cen[i] = $urandom;
        end
        if (mode < 12) return b;
        if (mode < 18) begin
            for (int i = 0; i < 3; i++) b.cen[i] = 32'($urandom_range(0, 400000) - 200000);
            return b;
        end
        span = 2 * coef_delta[b.typ] + coef_delta[b.typ] / 10 + 2;
        target = coef_r0[b.typ] + longint'($urandom_range(0, 32'(2 * span))) - span;
        if (target < 0) target = -target;
        if (target > FAR_EDGE - 40000) target = FAR_EDGE - 40000;
        pi = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) begin
            delr[i] = longint'($urandom_range(0, 32'(target / 32 + 2))) - (target / 64 + 1);
        end
        delr[pi] = $urandom_range(0, 1) ? target : -target;
        for (int i = 0; i < 3; i++) begin
            b.cen[i] = 32'(delr[i] - site_ofs(b.axa[i]) + site_ofs(b.axb[i]));
        end
        return b;
    endfunction

    function automatic bit take_gap();
        return !no_gaps && $urandom_range(0, 99) < 37;
    endfunction

    // Register write on the configuration port, mirrored into the coefficients.
    task automatic write_coef(int idx, longint value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(4 * idx);
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        unique case (idx % REGS_PER_TYPE)
            REG_K: coef_k[idx / REGS_PER_TYPE] = value & 24'hFFFFFF;
            REG_DELTA: coef_delta[idx / REGS_PER_TYPE] = value & 24'hFFFFFF;
            default: coef_r0[idx / REGS_PER_TYPE] = value & 24'hFFFFFF;
        endcase
    endtask

    task automatic write_set(longint k1, longint d1, longint r1,
                             longint k2, longint d2, longint r2);
        write_coef(REG_K, k1);
        write_coef(REG_DELTA, d1);
        write_coef(REG_R0, r1);
        write_coef(REGS_PER_TYPE + REG_K, k2);
        write_coef(REGS_PER_TYPE + REG_DELTA, d2);
        write_coef(REGS_PER_TYPE + REG_R0, r2);
    endtask

    // Drives one bond word and waits for its handshake.
    task automatic send_bond(bond_t b, bit typed, res_t res);
        if (take_gap()) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while (take_gap());
        end
        s_bond_type <= b.typ;
        s_center_dx <= b.cen[0];
        s_center_dy <= b.cen[1];
        s_center_dz <= b.cen[2];
        s_axis_a_x <= b.axa[0];
        s_axis_a_y <= b.axa[1];
        s_axis_a_z <= b.axa[2];
        s_axis_b_x <= b.axb[0];
        s_axis_b_y <= b.axb[1];
        s_axis_b_z <= b.axb[2];
        s_valid <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        expected_results.push_back(typed ? res : bond_force(b));
        bonds_sent++;
    endtask

    // Lets the pipeline run dry before the coefficients change.
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic random_bonds(int count);
        for (int i = 0; i < count; i++) send_bond(random_bond(), 1'b0, '0);
    endtask

    // Receiver stalls at random, except in the stretch without gaps.
    always @(posedge aclk) m_ready <= no_gaps || $urandom_range(0, 99) >= 37;

    // Result checker: each word against the oldest expectation.
    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got.force_v = {m_force_z, m_force_y, m_force_x};
            got.torque_a = {m_torque_a_z, m_torque_a_y, m_torque_a_x};
            got.torque_b = {m_torque_b_z, m_torque_b_y, m_torque_b_x};
            got.energy = m_bond_energy;
            got.status = m_bond_status;
            results_seen++;
            status_seen[got.status]++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result word: %p", got);
            end else begin
                want = expected_results.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch on result %0d:", results_seen);
                        $display("  force    exp %p got %p", want.force_v, got.force_v);
                        $display("  torque_a exp %p got %p", want.torque_a, got.torque_a);
                        $display("  torque_b exp %p got %p", want.torque_b, got.torque_b);
                        $display("  energy   exp %0d got %0d", $signed(want.energy),
                                 $signed(got.energy));
                        $display("  status   exp %0d got %0d", want.status, got.status);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any handshake while work is outstanding.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (s_valid || expected_results.size() != 0) begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        bond_row_t rows[$];
        for (int i = 0; i < 2; i++) begin
            coef_k[i] = K_RESET;
            coef_delta[i] = DELTA_RESET;
            coef_r0[i] = R0_RESET;
        end

        // Directed bonds at the reset coefficients (r0 49316, Delta 16384).
        rows.push_back('{mk_bond(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, flat_result(STAT_BAD)});
        rows.push_back('{mk_bond(1, 0, 0, 0, 16384, 0, 0, 16384, 0, 0), 1,
                         flat_result(STAT_BAD)});
        rows.push_back('{mk_bond(0, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         flat_result(STAT_BAD)});
        rows.push_back('{mk_bond(1, -2147483648, -2147483648, 2147483647, -16384, -16384,
                                 -16384, 16384, 16384, 16384), 1, flat_result(STAT_BAD)});
        rows.push_back('{mk_bond(0, 82084, 0, 0, 0, 0, 0, 0, 0, 0), 1, flat_result(STAT_BAD)});
        rows.push_back('{mk_bond(1, 0, 0, 16548, 0, 0, 0, 0, 0, 0), 1, flat_result(STAT_BAD)});
        rows.push_back('{mk_bond(0, 49316, 0, 0, 0, 0, 0, 0, 0, 0), 1, flat_result(STAT_OK)});
        rows.push_back('{mk_bond(0, 52000, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_bond(1, 0, -45000, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_bond(0, 65045, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_bond(0, 65700, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_bond(1, 0, 0, -32932, 0, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_bond(0, 70000, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_bond(1, 20000, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_bond(0, 30000, 30000, 30000, 16384, -16384, 8000,
                                 -16384, 16384, -8000), 0, '0});
        rows.push_back('{mk_bond(1, -40000, 25000, -10000, -16384, 0, 16384,
                                 0, -16384, 16384), 0, '0});
        rows.push_back('{mk_bond(0, 34000, -34000, 5000, 11585, 11585, 0,
                                 -11585, 0, 11585), 0, '0});
        rows.push_back('{mk_bond(1, 0, 60000, 30000, 0, 16384, 0, 0, -16384, 0), 0, '0});

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_bond(rows[i].bond, rows[i].typed, rows[i].res);
        random_bonds(230);
        no_gaps = 1'b1;
        random_bonds(120);
        no_gaps = 1'b0;

        // Coefficient extremes: stiff and narrow on one type, soft and wide on the other.
        drain();
        write_set(24'hFFFFFF, 1, 0, 0, 24'hFFFFFF, 24'hFFFFFF);
        random_bonds(120);
        drain();
        write_set(1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 3, 200000);
        random_bonds(120);
        drain();
        write_set($urandom_range(0, 24'hFFFFF), $urandom_range(4000, 60000),
                  $urandom_range(0, 200000), $urandom_range(0, 24'hFFFFFF),
                  $urandom_range(1, 60000), $urandom_range(0, 24'hFFFFFF));
        random_bonds(120);
        drain();
        write_set(K_RESET, DELTA_RESET, R0_RESET, 196608, 20000, 70000);
        random_bonds(120);
        drain();

        $display("Checked %0d bonds over five coefficient settings, results by status:",
                 bonds_sent);
        $display("  ok %0d, near limit %0d, past limit %0d, bad bond %0d",
                 status_seen[STAT_OK], status_seen[STAT_NEAR], status_seen[STAT_PAST],
                 status_seen[STAT_BAD]);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
